FILE: src/mml_song_parser_macros.svh
//------------------------------------------------------------------------------
// mml_song_parser_macros.svh
// Assertion macros used by the song parser's job queue.
//------------------------------------------------------------------------------
`ifndef MML_SONG_PARSER_MACROS_SVH
`define MML_SONG_PARSER_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define MSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msp assertion failed");

// Next-cycle implication, quiet during reset.
`define MSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msp assertion failed");

`endif

FILE: src/msp_pkg.sv
//------------------------------------------------------------------------------
// msp_pkg
// Types, constants and tables of the song parser.
//------------------------------------------------------------------------------
package msp_pkg;

    localparam int LEN_W   = 16;
    localparam int TEMPO_W = 9;
    localparam int VOL_W   = 7;
    localparam int IDX_W   = 7;
    localparam int FREQ_W  = 13;
    localparam int DUR_W   = 14;
    localparam int DUTY_W  = 10;
    localparam int CNT_OUT_W = 7;
    localparam int PROD_W  = TEMPO_W + LEN_W;
    localparam int DVD_W   = 18;

    localparam logic [DVD_W-1:0] DUR_DIVIDEND = 18'd240000;
    localparam logic [15:0] TEMPO_MIN = 16'd30;
    localparam logic [15:0] TEMPO_MAX = 16'd400;
    localparam logic [15:0] VOL_MAX   = 16'd100;
    localparam logic [DUR_W-1:0] DUR_FLOOR = 14'd15;
    localparam logic [12:0] DUTY_RECIP = 13'd5243;

    localparam logic [2:0] LETTER_REST = 3'd7;
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_SHARP = 2'd1;
    localparam logic [1:0] ACC_FLAT  = 2'd2;

    typedef struct packed {
        logic                 note_valid;
        logic                 last;
        logic                 empty;
        logic                 rest;
        logic                 dotted;
        logic [IDX_W-1:0]     idx;
        logic [VOL_W-1:0]     vol;
        logic [TEMPO_W-1:0]   tempo;
        logic [LEN_W-1:0]     len;
        logic [CNT_OUT_W-1:0] count;
    } job_t;

    function automatic logic [3:0] semitone(input logic [2:0] letter);
        logic [3:0] s;
        case (letter)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd2;
            3'd2:    s = 4'd4;
            3'd3:    s = 4'd5;
            3'd4:    s = 4'd7;
            3'd5:    s = 4'd9;
            3'd6:    s = 4'd11;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    function automatic logic [FREQ_W-1:0] freq_lookup(input logic [IDX_W-1:0] idx);
        logic [FREQ_W-1:0] f;
        case (idx)
            7'd0: f = 13'd16;    7'd1: f = 13'd17;    7'd2: f = 13'd18;    7'd3: f = 13'd19;
            7'd4: f = 13'd21;    7'd5: f = 13'd22;    7'd6: f = 13'd23;    7'd7: f = 13'd24;
            7'd8: f = 13'd26;    7'd9: f = 13'd28;    7'd10: f = 13'd29;   7'd11: f = 13'd31;
            7'd12: f = 13'd33;   7'd13: f = 13'd35;   7'd14: f = 13'd37;   7'd15: f = 13'd39;
            7'd16: f = 13'd41;   7'd17: f = 13'd44;   7'd18: f = 13'd46;   7'd19: f = 13'd49;
            7'd20: f = 13'd52;   7'd21: f = 13'd55;   7'd22: f = 13'd58;   7'd23: f = 13'd62;
            7'd24: f = 13'd65;   7'd25: f = 13'd69;   7'd26: f = 13'd73;   7'd27: f = 13'd78;
            7'd28: f = 13'd82;   7'd29: f = 13'd87;   7'd30: f = 13'd92;   7'd31: f = 13'd98;
            7'd32: f = 13'd104;  7'd33: f = 13'd110;  7'd34: f = 13'd117;  7'd35: f = 13'd123;
            7'd36: f = 13'd131;  7'd37: f = 13'd139;  7'd38: f = 13'd147;  7'd39: f = 13'd156;
            7'd40: f = 13'd165;  7'd41: f = 13'd175;  7'd42: f = 13'd185;  7'd43: f = 13'd196;
            7'd44: f = 13'd208;  7'd45: f = 13'd220;  7'd46: f = 13'd233;  7'd47: f = 13'd247;
            7'd48: f = 13'd262;  7'd49: f = 13'd277;  7'd50: f = 13'd294;  7'd51: f = 13'd311;
            7'd52: f = 13'd330;  7'd53: f = 13'd349;  7'd54: f = 13'd370;  7'd55: f = 13'd392;
            7'd56: f = 13'd415;  7'd57: f = 13'd440;  7'd58: f = 13'd466;  7'd59: f = 13'd494;
            7'd60: f = 13'd523;  7'd61: f = 13'd554;  7'd62: f = 13'd587;  7'd63: f = 13'd622;
            7'd64: f = 13'd659;  7'd65: f = 13'd698;  7'd66: f = 13'd740;  7'd67: f = 13'd784;
            7'd68: f = 13'd831;  7'd69: f = 13'd880;  7'd70: f = 13'd932;  7'd71: f = 13'd988;
            7'd72: f = 13'd1047; 7'd73: f = 13'd1109; 7'd74: f = 13'd1175; 7'd75: f = 13'd1245;
            7'd76: f = 13'd1319; 7'd77: f = 13'd1397; 7'd78: f = 13'd1480; 7'd79: f = 13'd1568;
            7'd80: f = 13'd1661; 7'd81: f = 13'd1760; 7'd82: f = 13'd1865; 7'd83: f = 13'd1976;
            7'd84: f = 13'd2093; 7'd85: f = 13'd2217; 7'd86: f = 13'd2349; 7'd87: f = 13'd2489;
            7'd88: f = 13'd2637; 7'd89: f = 13'd2794; 7'd90: f = 13'd2960; 7'd91: f = 13'd3136;
            7'd92: f = 13'd3322; 7'd93: f = 13'd3520; 7'd94: f = 13'd3729; 7'd95: f = 13'd3951;
            7'd96: f = 13'd4186; 7'd97: f = 13'd4435; 7'd98: f = 13'd4699; 7'd99: f = 13'd4978;
            7'd100: f = 13'd5274; 7'd101: f = 13'd5588; 7'd102: f = 13'd5920;
            7'd103: f = 13'd6272; 7'd104: f = 13'd6645; 7'd105: f = 13'd7040;
            7'd106: f = 13'd7459; 7'd107: f = 13'd7902;
            default: f = 13'd0;
        endcase
        return f;
    endfunction

endpackage

FILE: src/mml_song_parser.sv
//------------------------------------------------------------------------------
// mml_song_parser
// Music macro language song parser: characters in, notes out.
//------------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  input     | in_valid / in_ready  | ch, end_of_song
//  output    | out_valid / out_ready| freq_hz, note_ms, duty, note_valid,
//            |                      | last, note_count, song_empty
//
//  The parser takes one character beat per cycle while the two-entry job
//  queue has room. Each note, or end result with a note, goes through the
//  note engine in turn: load, multiply, 18 restoring-divide steps for the
//  duration, scale and the output register; an end beat without a note
//  goes from load to the output register. The divider sets the note rate.
//  Reset clears all settings and control state at once; there is no
//  clearing pass. A stalled output holds the engine, the queue fills, and
//  in_ready drops until a slot frees.
//------------------------------------------------------------------------------
module mml_song_parser #(
    parameter int NOTE_CAP = 96
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    ch,
    input  logic                          end_of_song,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [msp_pkg::FREQ_W-1:0]    freq_hz,
    output logic [msp_pkg::DUR_W-1:0]     note_ms,
    output logic [msp_pkg::DUTY_W-1:0]    duty,
    output logic                          note_valid,
    output logic                          last,
    output logic [msp_pkg::CNT_OUT_W-1:0] note_count,
    output logic                          song_empty
);
    import msp_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    job_t push_data;
    job_t head;

    // Take a beat whenever the queue can absorb the job it may produce.
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    msp_front #(
        .NOTE_CAP (NOTE_CAP)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .ch          (ch),
        .end_of_song (end_of_song),
        .push        (push),
        .push_data   (push_data)
    );

    msp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    msp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .freq_hz     (freq_hz),
        .note_ms     (note_ms),
        .duty        (duty),
        .note_valid  (note_valid),
        .last        (last),
        .note_count  (note_count),
        .song_empty  (song_empty)
    );

endmodule

FILE: src/msp_queue.sv
//------------------------------------------------------------------------------
// msp_queue
// Two-entry job queue between the character parser and the note engine.
//------------------------------------------------------------------------------
`include "mml_song_parser_macros.svh"

module msp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  msp_pkg::job_t push_data,
    input  logic          pop,
    output msp_pkg::job_t head,
    output logic          full,
    output logic          empty
);
    import msp_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;
    localparam int CNT_W = 2;

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `MSP_ASSERT_NOW(a_no_overflow, push, !full)
    `MSP_ASSERT_NOW(a_no_underflow, pop, !empty)
    `MSP_ASSERT_NEXT(a_count_holds, !push && !pop, $stable(cnt_reg))

endmodule

FILE: src/msp_front.sv
//------------------------------------------------------------------------------
// msp_front
// Character parser: tracks song settings and queues one job per note, up to
// NOTE_CAP, with the song's end marked on the last note's job or on its own job.
module msp_front #(
    parameter int NOTE_CAP = 96
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    ch,
    input  logic          end_of_song,
    output logic          push,
    output msp_pkg::job_t push_data
);
    import msp_pkg::*;

    localparam int CNT_W = $clog2(NOTE_CAP + 1);

    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_V    = 8'h56;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    localparam logic [1:0] CMD_T = 2'd0;
    localparam logic [1:0] CMD_O = 2'd1;
    localparam logic [1:0] CMD_L = 2'd2;
    localparam logic [1:0] CMD_V = 2'd3;

    localparam logic [3:0] OCT_RESET = 4'd5;
    localparam logic [3:0] OCT_MAX   = 4'd8;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CMD,
        PH_LETTER,
        PH_LENGTH
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [15:0]      accum_reg, accum_next;
    logic             seen_reg, seen_next;
    logic [15:0]      tempo_reg, tempo_next;
    logic [3:0]       oct_reg, oct_next;
    logic [15:0]      deflen_reg, deflen_next;
    logic [15:0]      vol_reg, vol_next;
    logic [2:0]       letter_reg, letter_next;
    logic [1:0]       acc_reg, acc_next;
    logic             dotted_reg, dotted_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [7:0]          c_up;
    logic                is_digit;
    logic [3:0]          dval;
    logic [19:0]         acc_ten;
    logic [15:0]         accum_dig;
    logic [15:0]         len_sel;
    logic [TEMPO_W-1:0]  tempo_c;
    logic [VOL_W-1:0]    vol_c;
    logic [7:0]          midi;
    logic [7:0]          midi_c;
    logic                cap_ok;
    logic [CNT_W-1:0]    count_inc;
    logic [CNT_W+6:0]    count_ext;
    logic [CNT_W+6:0]    count_inc_ext;
    logic                do_start;
    logic                do_finish;
    logic                finish_dot;
    job_t                note_job;

    // Digit accumulation with saturation.
    always_comb
    begin
        c_up     = ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) ? (ch - 8'd32) : ch;
        is_digit = (c_up >= CH_0) && (c_up <= CH_9);
        dval     = 4'(c_up - CH_0);
        acc_ten  = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0} + 20'(dval);
        accum_dig = (acc_ten > 20'd65535) ? 16'hFFFF : acc_ten[15:0];
    end

    // Note job built from the current settings.
    always_comb
    begin
        len_sel = (seen_reg && (accum_reg != '0)) ? accum_reg : deflen_reg;
        if (len_sel == '0)
        begin
            len_sel = 16'd1;
        end
        if (tempo_reg < TEMPO_MIN)
        begin
            tempo_c = TEMPO_W'(TEMPO_MIN);
        end
        else if (tempo_reg > TEMPO_MAX)
        begin
            tempo_c = TEMPO_W'(TEMPO_MAX);
        end
        else
        begin
            tempo_c = tempo_reg[TEMPO_W-1:0];
        end
        vol_c = (vol_reg > VOL_MAX) ? VOL_W'(VOL_MAX) : vol_reg[VOL_W-1:0];
        midi  = {1'b0, oct_reg, 3'b000} + {2'b00, oct_reg, 2'b00} + 8'd12
                + {4'd0, semitone(letter_reg)};
        if (acc_reg == ACC_SHARP)
        begin
            midi = midi + 8'd1;
        end
        else if (acc_reg == ACC_FLAT)
        begin
            midi = midi - 8'd1;
        end
        midi_c = (midi < 8'd12) ? 8'd12 : ((midi > 8'd119) ? 8'd119 : midi);
        cap_ok = (32'(count_reg) < NOTE_CAP);
        count_inc     = count_reg + 1'b1;
        count_ext     = {7'd0, count_reg};
        count_inc_ext = {7'd0, count_inc};

        note_job.note_valid = 1'b1;
        note_job.last       = 1'b0;
        note_job.empty      = 1'b0;
        note_job.rest       = (letter_reg == LETTER_REST);
        note_job.dotted     = dotted_reg;
        note_job.idx        = IDX_W'(midi_c - 8'd12);
        note_job.vol        = vol_c;
        note_job.tempo      = tempo_c;
        note_job.len        = len_sel;
        note_job.count      = count_inc_ext[CNT_OUT_W-1:0];
    end

    // Parser next-state.
    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        accum_next  = accum_reg;
        seen_next   = seen_reg;
        tempo_next  = tempo_reg;
        oct_next    = oct_reg;
        deflen_next = deflen_reg;
        vol_next    = vol_reg;
        letter_next = letter_reg;
        acc_next    = acc_reg;
        dotted_next = dotted_reg;
        count_next  = count_reg;
        push        = 1'b0;
        push_data   = note_job;
        do_start    = 1'b0;
        do_finish   = 1'b0;
        finish_dot  = 1'b0;

        if (accept && end_of_song)
        begin
            push = 1'b1;
            if (((phase_reg == PH_LETTER) || (phase_reg == PH_LENGTH)) && cap_ok)
            begin
                push_data.last = 1'b1;
            end
            else
            begin
                push_data            = '0;
                push_data.last       = 1'b1;
                push_data.count      = count_ext[CNT_OUT_W-1:0];
                push_data.empty      = (count_reg == '0);
            end
            phase_next  = PH_IDLE;
            cmd_next    = CMD_T;
            accum_next  = '0;
            seen_next   = 1'b0;
            tempo_next  = 16'd120;
            oct_next    = OCT_RESET;
            deflen_next = 16'd4;
            vol_next    = 16'd70;
            letter_next = '0;
            acc_next    = ACC_NONE;
            dotted_next = 1'b0;
            count_next  = '0;
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_CMD:
                begin
                    if (is_digit)
                    begin
                        accum_next = accum_dig;
                        seen_next  = 1'b1;
                    end
                    else
                    begin
                        if (seen_reg)
                        begin
                            unique case (cmd_reg)
                                CMD_T: tempo_next = accum_reg;
                                CMD_O: oct_next = (accum_reg > 16'd8) ? OCT_MAX
                                                                       : accum_reg[3:0];
                                CMD_L: deflen_next = accum_reg;
                                CMD_V: vol_next = accum_reg;
                                default: tempo_next = accum_reg;
                            endcase
                        end
                        do_start = 1'b1;
                    end
                end
                PH_LETTER, PH_LENGTH:
                begin
                    if ((phase_reg == PH_LETTER) && ((c_up == CH_HASH) || (c_up == CH_PLUS)))
                    begin
                        acc_next   = ACC_SHARP;
                        phase_next = PH_LENGTH;
                    end
                    else if ((phase_reg == PH_LETTER) && (c_up == CH_DASH))
                    begin
                        acc_next   = ACC_FLAT;
                        phase_next = PH_LENGTH;
                    end
                    else if (is_digit)
                    begin
                        accum_next = accum_dig;
                        seen_next  = 1'b1;
                        phase_next = PH_LENGTH;
                    end
                    else if (c_up == CH_DOT)
                    begin
                        do_finish  = 1'b1;
                        finish_dot = 1'b1;
                    end
                    else
                    begin
                        do_finish = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase

            if (do_finish)
            begin
                phase_next  = PH_IDLE;
                dotted_next = 1'b0;
                if (cap_ok)
                begin
                    push             = 1'b1;
                    push_data.dotted = dotted_reg || finish_dot;
                    count_next       = count_inc;
                end
            end

            // Start a new token; the octave steps act on any value just set.
            if (do_start)
            begin
                phase_next = PH_IDLE;
                accum_next = '0;
                seen_next  = 1'b0;
                if ((c_up == CH_T) || (c_up == CH_O) || (c_up == CH_L) || (c_up == CH_V))
                begin
                    cmd_next   = (c_up == CH_T) ? CMD_T : (c_up == CH_O) ? CMD_O :
                                 (c_up == CH_L) ? CMD_L : CMD_V;
                    phase_next = PH_CMD;
                end
                else if (c_up == CH_GT)
                begin
                    if (oct_next < OCT_MAX)
                    begin
                        oct_next = oct_next + 4'd1;
                    end
                end
                else if (c_up == CH_LT)
                begin
                    if (oct_next != 4'd0)
                    begin
                        oct_next = oct_next - 4'd1;
                    end
                end
                else if ((c_up >= CH_A) && (c_up <= CH_G))
                begin
                    // A and B sit above C..G in the scale order.
                    letter_next = (c_up < CH_C) ? 3'(c_up - CH_A + 8'd5)
                                                : 3'(c_up - CH_C);
                    acc_next    = ACC_NONE;
                    dotted_next = 1'b0;
                    phase_next  = PH_LETTER;
                end
                else if (c_up == CH_R)
                begin
                    letter_next = LETTER_REST;
                    acc_next    = ACC_NONE;
                    dotted_next = 1'b0;
                    phase_next  = PH_LENGTH;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            cmd_reg    <= CMD_T;
            accum_reg  <= '0;
            seen_reg   <= 1'b0;
            tempo_reg  <= 16'd120;
            oct_reg    <= OCT_RESET;
            deflen_reg <= 16'd4;
            vol_reg    <= 16'd70;
            letter_reg <= '0;
            acc_reg    <= ACC_NONE;
            dotted_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            accum_reg  <= accum_next;
            seen_reg   <= seen_next;
            tempo_reg  <= tempo_next;
            oct_reg    <= oct_next;
            deflen_reg <= deflen_next;
            vol_reg    <= vol_next;
            letter_reg <= letter_next;
            acc_reg    <= acc_next;
            dotted_reg <= dotted_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/msp_back.sv
//------------------------------------------------------------------------------
// msp_back
// Note engine: table lookup, duty scaling, iterative duration divide and
// the output register.
//------------------------------------------------------------------------------
module msp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  msp_pkg::job_t                 head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [msp_pkg::FREQ_W-1:0]    freq_hz,
    output logic [msp_pkg::DUR_W-1:0]     note_ms,
    output logic [msp_pkg::DUTY_W-1:0]    duty,
    output logic                          note_valid,
    output logic                          last,
    output logic [msp_pkg::CNT_OUT_W-1:0] note_count,
    output logic                          song_empty
);
    import msp_pkg::*;

    localparam int STEP_W = $clog2(DVD_W);

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_FIN,
        B_OUT
    } bstate_t;

    bstate_t           state_reg;
    job_t              job_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W:0]   rem_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic [DUR_W-1:0]  dur_reg;

    logic [16:0]       duty_x;
    logic [29:0]       duty_p;
    logic [PROD_W:0]   rem_sh;
    logic [DUR_W-1:0]  d_base;
    logic [DUR_W-1:0]  d_dot;
    logic              load_out;

    always_comb
    begin
        duty_x = {job_reg.vol, 10'd0} - {10'd0, job_reg.vol};
        duty_p = 30'(duty_x) * 30'(DUTY_RECIP);
        rem_sh = {rem_reg[PROD_W-1:0], dvd_reg[DVD_W-1]};
        d_base = quo_reg[DUR_W-1:0];
        d_dot  = job_reg.dotted ? (d_base + (d_base >> 1)) : d_base;
        if (d_dot < DUR_FLOOR)
        begin
            d_dot = DUR_FLOOR;
        end
    end

    assign pop      = (state_reg == B_IDLE) && !empty;
    // Load the output register once the previous beat has left it.
    assign load_out = (state_reg == B_OUT) && (!out_valid || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            out_valid   <= 1'b0;
            job_reg     <= '0;
            prod_reg    <= '0;
            rem_reg     <= '0;
            dvd_reg     <= '0;
            quo_reg     <= '0;
            step_reg    <= '0;
            freq_reg    <= '0;
            duty_reg    <= '0;
            dur_reg     <= '0;
            freq_hz     <= '0;
            note_ms     <= '0;
            duty        <= '0;
            note_valid  <= 1'b0;
            last        <= 1'b0;
            note_count  <= '0;
            song_empty  <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        job_reg  <= head;
                        freq_reg <= '0;
                        duty_reg <= '0;
                        dur_reg  <= '0;
                        state_reg <= head.note_valid ? B_MUL : B_OUT;
                    end
                end
                B_MUL:
                begin
                    prod_reg <= PROD_W'(job_reg.tempo) * PROD_W'(job_reg.len);
                    if (!job_reg.rest)
                    begin
                        freq_reg <= freq_lookup(job_reg.idx);
                        duty_reg <= duty_p[28:19];
                    end
                    rem_reg   <= '0;
                    dvd_reg   <= DUR_DIVIDEND;
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV:
                begin
                    // One restoring-divide bit per cycle.
                    if (rem_sh >= {1'b0, prod_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, prod_reg};
                        quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
                    end
                    dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DVD_W - 1))
                    begin
                        state_reg <= B_FIN;
                    end
                end
                B_FIN:
                begin
                    dur_reg   <= d_dot;
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (load_out)
                    begin
                        freq_hz     <= freq_reg;
                        note_ms     <= dur_reg;
                        duty        <= duty_reg;
                        note_valid  <= job_reg.note_valid;
                        last        <= job_reg.last;
                        note_count  <= job_reg.count;
                        song_empty  <= job_reg.empty;
                        state_reg   <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule
